// ===== sv/ucbt_pkg.sv =====
// ucbt_pkg: shared types and constants for the UTF-8 / CJK bigram tokenizer.
// Holds the result and result-group types and the group builder used by the
// front classifier, the group queue and the back serializer. No dependencies.
package ucbt_pkg;

    // result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // lead bytes of a three-byte character
    localparam logic [7:0] LEAD_LO = 8'hE4;
    localparam logic [7:0] LEAD_HI = 8'hE9;

    // token limit register
    localparam int         TOKEN_CAP        = 32;
    localparam logic [5:0] TOKEN_LIMIT_MAX  = 6'd32;
    localparam logic [5:0] TOKEN_LIMIT_INIT = 6'd32;
    localparam int         PADDR_W          = 3;
    localparam logic       REG_TOKEN_LIMIT  = 1'b0;

    // one input item causes at most four results
    localparam int MAX_RES = 4;
    localparam int RES_IDX_W = 2;
    localparam int RES_CNT_W = 3;

    // group queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [5:0] total;
    } res_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0]  count;
        res_t [MAX_RES-1:0]    res;
    } grp_t;

    // Append one result to a group.
    function automatic grp_t grp_add(grp_t g, logic [1:0] kind, logic [7:0] data,
                                     logic [5:0] total);
        grp_t r;
        r = g;
        if (g.count < RES_CNT_W'(MAX_RES))
        begin
            r.res[g.count[RES_IDX_W-1:0]].kind  = kind;
            r.res[g.count[RES_IDX_W-1:0]].data  = data;
            r.res[g.count[RES_IDX_W-1:0]].total = total;
            r.count = g.count + RES_CNT_W'(1);
        end
        return r;
    endfunction

endpackage

// ===== sv/ucbt_front.sv =====
// ucbt_front: accepts query bytes, tracks word / character / pair state and
// builds the group of results each item causes.
// Depends on ucbt_pkg.
module ucbt_front import ucbt_pkg::*;
#(
    parameter int MAX_UNITS      = 64,
    parameter int MAX_WORD_BYTES = 63
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       has_byte,
    input  logic [7:0] in_byte,
    input  logic       end_of_query,
    input  logic [5:0] token_limit,
    output grp_t       grp
);

    localparam int UNIT_W = $clog2(MAX_UNITS + 1);
    localparam int WORD_W = $clog2(MAX_WORD_BYTES + 1);

    logic [WORD_W-1:0] word_length_reg, word_length_next;
    logic              in_word_reg, in_word_next;
    logic [1:0]        phase_reg, phase_next;
    logic              open_single_reg, open_single_next;
    logic              pair_second_reg, pair_second_next;
    logic              suppressed_reg, suppressed_next;
    logic [UNIT_W-1:0] unit_count_reg, unit_count_next;
    logic [5:0]        token_count_reg, token_count_next;

    logic [5:0] eff_limit;
    logic       is_lead;
    logic       is_alnum;
    logic       unit_room;

    assign eff_limit = (token_limit > TOKEN_LIMIT_MAX) ? TOKEN_LIMIT_MAX : token_limit;
    assign is_lead   = (in_byte >= LEAD_LO) && (in_byte <= LEAD_HI);
    assign is_alnum  = (in_byte >= 8'h30 && in_byte <= 8'h39) ||
                       (in_byte >= 8'h41 && in_byte <= 8'h5A) ||
                       (in_byte >= 8'h61 && in_byte <= 8'h7A);
    assign unit_room = unit_count_reg < UNIT_W'(MAX_UNITS);

    always_comb
    begin
        word_length_next = word_length_reg;
        in_word_next     = in_word_reg;
        phase_next       = phase_reg;
        open_single_next = open_single_reg;
        pair_second_next = pair_second_reg;
        suppressed_next  = suppressed_reg;
        unit_count_next  = unit_count_reg;
        token_count_next = token_count_reg;
        grp              = '0;

        if (has_byte)
        begin
            if (phase_reg != 2'd0)
            begin
                // continuation byte of a character
                if (!suppressed_reg)
                    grp = grp_add(grp, KIND_BYTE, in_byte, token_count_next);
                if (phase_reg >= 2'd2)
                begin
                    phase_next = 2'd0;
                    if (pair_second_reg && !suppressed_reg)
                    begin
                        token_count_next = token_count_next + 6'd1;
                        grp = grp_add(grp, KIND_END, 8'd0, token_count_next);
                        pair_second_next = 1'b0;
                    end
                    suppressed_next = 1'b0;
                end
                else
                begin
                    phase_next = phase_reg + 2'd1;
                end
            end
            else if (is_lead)
            begin
                // close any open word
                if (in_word_reg && !suppressed_reg)
                begin
                    token_count_next = token_count_next + 6'd1;
                    grp = grp_add(grp, KIND_END, 8'd0, token_count_next);
                end
                in_word_next     = 1'b0;
                word_length_next = '0;
                suppressed_next  = 1'b0;
                if (open_single_reg)
                begin
                    if (unit_room)
                    begin
                        unit_count_next  = unit_count_reg + UNIT_W'(1);
                        open_single_next = 1'b0;
                        pair_second_next = 1'b1;
                    end
                    else
                    begin
                        suppressed_next = 1'b1;
                    end
                end
                else if (unit_room && (token_count_next < eff_limit))
                begin
                    unit_count_next  = unit_count_reg + UNIT_W'(1);
                    open_single_next = 1'b1;
                end
                else
                begin
                    suppressed_next = 1'b1;
                end
                if (!suppressed_next)
                    grp = grp_add(grp, KIND_BYTE, in_byte, token_count_next);
                phase_next = 2'd1;
            end
            else if (is_alnum)
            begin
                if (!in_word_reg)
                begin
                    // a word closes a lone character
                    if (open_single_reg)
                    begin
                        token_count_next = token_count_next + 6'd1;
                        grp = grp_add(grp, KIND_END, 8'd0, token_count_next);
                        open_single_next = 1'b0;
                    end
                    in_word_next     = 1'b1;
                    word_length_next = '0;
                    if (unit_room && (token_count_next < eff_limit))
                    begin
                        unit_count_next = unit_count_reg + UNIT_W'(1);
                        suppressed_next = 1'b0;
                    end
                    else
                    begin
                        suppressed_next = 1'b1;
                    end
                end
                if (word_length_next < WORD_W'(MAX_WORD_BYTES))
                begin
                    if (!suppressed_next)
                        grp = grp_add(grp, KIND_BYTE, in_byte, token_count_next);
                    word_length_next = word_length_next + WORD_W'(1);
                end
            end
            else
            begin
                // separator
                if (in_word_reg && !suppressed_reg)
                begin
                    token_count_next = token_count_next + 6'd1;
                    grp = grp_add(grp, KIND_END, 8'd0, token_count_next);
                end
                in_word_next     = 1'b0;
                word_length_next = '0;
                suppressed_next  = 1'b0;
            end
        end

        if (end_of_query)
        begin
            if ((pair_second_next && !suppressed_next) || open_single_next ||
                (in_word_next && !suppressed_next))
            begin
                token_count_next = token_count_next + 6'd1;
                grp = grp_add(grp, KIND_END, 8'd0, token_count_next);
            end
            grp = grp_add(grp, KIND_DONE, 8'd0, token_count_next);
            word_length_next = '0;
            in_word_next     = 1'b0;
            phase_next       = 2'd0;
            open_single_next = 1'b0;
            pair_second_next = 1'b0;
            suppressed_next  = 1'b0;
            unit_count_next  = '0;
            token_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_length_reg <= '0;
            in_word_reg     <= 1'b0;
            phase_reg       <= 2'd0;
            open_single_reg <= 1'b0;
            pair_second_reg <= 1'b0;
            suppressed_reg  <= 1'b0;
            unit_count_reg  <= '0;
            token_count_reg <= '0;
        end
        else if (accept)
        begin
            word_length_reg <= word_length_next;
            in_word_reg     <= in_word_next;
            phase_reg       <= phase_next;
            open_single_reg <= open_single_next;
            pair_second_reg <= pair_second_next;
            suppressed_reg  <= suppressed_next;
            unit_count_reg  <= unit_count_next;
            token_count_reg <= token_count_next;
        end
    end

endmodule

// ===== sv/ucbt_queue.sv =====
// ucbt_queue: short queue of result groups between front and back.
// Push and pop may happen in the same cycle. Depends on ucbt_pkg.
module ucbt_queue import ucbt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  grp_t push_grp,
    input  logic pop,
    output grp_t head_grp,
    output logic empty,
    output logic full
);

    grp_t                   mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push;
    logic                   do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head_grp = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QUEUE_CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/ucbt_back.sv =====
// ucbt_back: unless stalled, walks the head group one result per cycle
// to the output register; flags each group's last. Depends on ucbt_pkg.
module ucbt_back import ucbt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  grp_t       head_grp,
    input  logic       empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] out_byte,
    output logic [5:0] token_total,
    output logic       last_of_run
);

    logic [RES_IDX_W-1:0] pos_reg, pos_next;
    logic                 valid_reg, valid_next;
    res_t                 res_reg;
    logic                 last_reg;
    logic                 load;
    logic                 at_last;

    assign load    = !empty && (!valid_reg || !out_stall);
    assign at_last = ({1'b0, pos_reg} == (head_grp.count - RES_CNT_W'(1)));
    assign pop     = load && at_last;

    always_comb
    begin
        pos_next   = pos_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            pos_next   = at_last ? '0 : pos_reg + RES_IDX_W'(1);
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= head_grp.res[pos_reg];
            last_reg <= at_last;
        end
    end

    assign out_valid   = valid_reg;
    assign kind        = res_reg.kind;
    assign out_byte    = res_reg.data;
    assign token_total = res_reg.total;
    assign last_of_run = last_reg;

endmodule

// ===== sv/utf8_cjk_bigram_tokenizer_unit.sv =====
// utf8_cjk_bigram_tokenizer_unit: top level of the query tokenizer.
// Holds the token limit register; instantiates ucbt_front, ucbt_queue and
// ucbt_back. Depends on ucbt_pkg.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------
//   in      | in_valid / in_stall  | has_byte, in_byte, end_of_query
//   out     | out_valid / out_stall| kind, out_byte, token_total, last_of_run
//   cfg     | psel/penable/pwrite  | paddr, pwdata, prdata (token_limit at 0)
//
// One input transaction per cycle is taken while the group queue has room.
// The results of a taken item enter the queue as one group; they are then
// loaded from the queue head into the output register one per cycle while
// out_stall is low, so an item that makes several results holds the output
// until all have left, and the output port sets the rate when results cluster.
// in_stall is the queue-full flag; out_stall holds the output register.
// Reset clears all query state, the queue and sets token_limit to 32.
module utf8_cjk_bigram_tokenizer_unit import ucbt_pkg::*;
#(
    parameter int MAX_UNITS      = 64,
    parameter int MAX_WORD_BYTES = 63
)
(
    input  logic               clk,
    input  logic               rst_n,
    // input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               has_byte,
    input  logic [7:0]         in_byte,
    input  logic               end_of_query,
    // output channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         kind,
    output logic [7:0]         out_byte,
    output logic [5:0]         token_total,
    output logic               last_of_run,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [5:0] token_limit_reg;
    logic       cfg_write;
    logic       in_accept;
    logic       queue_full;
    logic       queue_empty;
    logic       queue_pop;
    grp_t       front_grp;
    grp_t       head_grp;

    // Register decode uses the word index only.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready &&
                       (paddr[2] == REG_TOKEN_LIMIT);
    assign prdata    = (paddr[2] == REG_TOKEN_LIMIT) ? {26'd0, token_limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            token_limit_reg <= TOKEN_LIMIT_INIT;
        else if (cfg_write)
            token_limit_reg <= pwdata[5:0];
    end

    // Stall the input only on a full queue; empty items are taken as well.
    assign in_stall  = queue_full;
    assign in_accept = in_valid && !queue_full;

    ucbt_front #(
        .MAX_UNITS      (MAX_UNITS),
        .MAX_WORD_BYTES (MAX_WORD_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .has_byte     (has_byte),
        .in_byte      (in_byte),
        .end_of_query (end_of_query),
        .token_limit  (token_limit_reg),
        .grp          (front_grp)
    );

    // Push only groups that carry at least one result.
    ucbt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_accept && (front_grp.count != '0)),
        .push_grp (front_grp),
        .pop      (queue_pop),
        .head_grp (head_grp),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    ucbt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_grp    (head_grp),
        .empty       (queue_empty),
        .pop         (queue_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .out_byte    (out_byte),
        .token_total (token_total),
        .last_of_run (last_of_run)
    );

endmodule
